>>> rtl/plc_pkg.sv
package plc_pkg;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_INS_POS   = 3'd2;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [7:0]         position;
  } plc_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] read_value;
  } plc_res_t;

  // per-cell control
  typedef struct packed {
    logic load;        // take the inserted word
    logic from_left;   // take the word of the cell nearer the front
    logic from_right;  // take the word of the cell nearer the back
    logic rd_sel;      // drive own word onto the read bus
  } plc_cell_ctrl_t;

endpackage

>>> rtl/plc_cell.sv
module plc_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  plc_pkg::plc_cell_ctrl_t ctrl_i,
  input  logic [DATA_WIDTH-1:0]   word_i,
  input  logic [DATA_WIDTH-1:0]   left_i,
  input  logic [DATA_WIDTH-1:0]   right_i,
  output logic [DATA_WIDTH-1:0]   data_o,
  output logic [DATA_WIDTH-1:0]   rd_o
);
  import plc_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = word_i;
    end else if (ctrl_i.from_left) begin
      data_d = left_i;
    end else if (ctrl_i.from_right) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = data_q & {DATA_WIDTH{ctrl_i.rd_sel}};

endmodule

>>> rtl/positional_list_store_unit.sv
// Ordered list store, front is position 1, built as a row of word cells.
// Command channel: a beat (command, value, position) is taken on a rising
// edge with start high and busy low. busy is always low: a command may be
// issued every cycle.
// Result channel: one beat per command, on res_o with result_valid_o high
// for exactly one cycle, the cycle after the command was taken (throughput
// 1 command per cycle). Inserts shift the cells behind the slot
// one step back, a front delete shifts every cell one step forward, all in
// the same cycle; reads select one cell onto an AND-OR bus.
// The receiver cannot stall; every result must be captured when strobed.
// Reset empties the list (count zero) and drops any pending result; the
// cell words themselves are not cleared and are never read while unused.
// entry_count carries the low five bits of the held count.
module positional_list_store_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  plc_pkg::plc_cmd_t cmd_i,
  output logic              busy,
  output logic              result_valid_o,
  output plc_pkg::plc_res_t res_o
);
  import plc_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  logic [CW-1:0]         count_q, count_d;
  logic                  valid_q;
  plc_res_t              res_q, res_d;
  logic [1:0]            status_d;
  logic                  accept;
  logic [CMPW-1:0]       pos_x, cnt_x, ins_idx;
  logic                  ins_en, del_front, rd_en;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0] rd_bus;
  plc_cell_ctrl_t        ctrl      [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_x  = CMPW'(cmd_i.position);
  assign cnt_x  = CMPW'(count_q);
  assign word   = DATA_WIDTH'($unsigned(cmd_i.value));

  always_comb begin
    count_d   = count_q;
    ins_en    = 1'b0;
    del_front = 1'b0;
    rd_en     = 1'b0;
    ins_idx   = '0;
    status_d  = ST_DONE;
    case (cmd_i.command)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        ins_idx = (cmd_i.command == CMD_INS_FRONT) ? '0 : cnt_x;
        if (cnt_x >= CMPW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      CMD_INS_POS: begin
        ins_idx = pos_x - CMPW'(1);
        if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
          status_d = ST_BADPOS;
        end else if (cnt_x >= CMPW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          del_front = (cmd_i.command == CMD_DEL_FRONT);
          count_d   = count_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          status_d = ST_BADPOS;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: ;
    endcase
    if (ins_en) begin
      count_d = count_q + CW'(1);
    end
  end

  // cell k: load at the slot, take left neighbour behind it, right on front delete
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;

    assign ctrl[k].load       = accept && ins_en && (ins_idx == CMPW'(k));
    assign ctrl[k].from_left  = accept && ins_en && (ins_idx < CMPW'(k));
    assign ctrl[k].from_right = accept && del_front;
    assign ctrl[k].rd_sel     = rd_en && (pos_x == CMPW'(k + 1));

    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end

    plc_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl[k]),
      .word_i (word),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_data[k]),
      .rd_o   (cell_rd[k])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
    res_d.status      = status_d;
    res_d.entry_count = 5'(count_d);
    res_d.read_value  = 32'(rd_bus);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = valid_q;
  assign res_o          = res_q;

endmodule

>>> rtl/plc_checker.sv
module plc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input plc_pkg::plc_res_t res_o
);
  import plc_pkg::*;

  // one result beat per accepted command, in the cycle after it
  a_res_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> result_valid_o)
    else $error("missing result beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !result_valid_o)
    else $error("result beat without command");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.status == ST_EMPTY |-> res_o.entry_count == 5'd0)
    else $error("empty status with nonzero count");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.status != ST_DONE |-> res_o.read_value == 32'sd0)
    else $error("read value on failed command");

endmodule

bind positional_list_store_unit plc_checker u_plc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .res_o         (res_o)
);
